// ===== hw/rtl/mfm_pkg.sv =====
// Shared types, constants and helpers for the MFM sector encoder.
// No dependencies; imported by mfm_word_gen and mfm_sector_encoder_unit.
package mfm_pkg;

    localparam logic [31:0] MASK_HALF    = 32'h5555_5555;
    localparam logic [15:0] FILL_WORD    = 16'haaaa;
    localparam logic [15:0] SYNC_WORD    = 16'h4489;
    localparam logic [7:0]  FORMAT_BYTE  = 8'hff;
    localparam logic [4:0]  SPT_RESET    = 5'd11;
    localparam logic [6:0]  LONG_LAST    = 7'd127;

    // word positions in the sector image
    localparam logic [9:0]  ADDR_DCK     = 10'd28;
    localparam logic [9:0]  ADDR_ODD     = 10'd32;
    localparam logic [9:0]  ADDR_EVEN    = 10'd288;

    // preamble step groups (step[4:2])
    localparam logic [2:0]  GRP_SYNC     = 3'd0;
    localparam logic [2:0]  GRP_HDR      = 3'd1;
    localparam logic [2:0]  GRP_HCK      = 3'd6;
    localparam logic [4:0]  STEP_PRE_END = 5'd28;

    typedef struct packed {
        logic [31:0] data;
        logic [31:0] hdr;
        logic [31:0] csum;
        logic [6:0]  idx;
        logic        first;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [9:0]  addr;
        logic [15:0] value;
        logic        last;
    } t_word;

    // Pick one 16-bit word of the odd/even split: odd hi, odd lo, even hi, even lo.
    function automatic logic [15:0] split_word(input logic [31:0] v, input logic [1:0] sel);
        logic [31:0] odd;
        logic [31:0] even;
        logic [15:0] w;
        odd  = (v >> 1) & MASK_HALF;
        even = v & MASK_HALF;
        unique case (sel)
            2'd0: w = odd[31:16];
            2'd1: w = odd[15:0];
            2'd2: w = even[31:16];
            2'd3: w = even[15:0];
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/mfm_word_gen.sv =====
// Word selector: maps a held item and a step index to one addressed output word.
// Depends on mfm_pkg.
module mfm_word_gen (
    input  mfm_pkg::t_item  i_item,
    input  logic [4:0]      i_step,
    output mfm_pkg::t_word  o_word
);
    import mfm_pkg::*;

    logic [31:0] hck;
    logic [1:0]  d;

    assign hck = ((i_item.hdr >> 1) & MASK_HALF) ^ (i_item.hdr & MASK_HALF);
    assign d   = i_step[1:0];

    always_comb begin
        o_word = '0;
        if (i_item.first && (i_step < STEP_PRE_END)) begin
            // preamble, header, label, header checksum
            o_word.addr = {5'd0, i_step};
            unique case (i_step[4:2])
                GRP_SYNC: o_word.value = i_step[1] ? SYNC_WORD : FILL_WORD;
                GRP_HDR:  o_word.value = split_word(i_item.hdr, d);
                GRP_HCK:  o_word.value = split_word(hck, d);
                default:  o_word.value = '0;
            endcase
            o_word.last = 1'b0;
        end else if (!i_item.first && (i_step[4:2] != 3'd0)) begin
            // data checksum after the last longword
            o_word.addr  = ADDR_DCK + {8'd0, d};
            o_word.value = split_word(i_item.csum, d);
            o_word.last  = (d == 2'd3);
        end else begin
            // data words of this longword
            o_word.addr  = (d[1] ? ADDR_EVEN : ADDR_ODD) + {2'd0, i_item.idx, d[0]};
            o_word.value = split_word(i_item.data, d);
            o_word.last  = (d == 2'd3) && !i_item.last;
        end
    end

endmodule

// ===== hw/rtl/mfm_sector_encoder_unit.sv =====
// Top level of the MFM odd/even sector encoder: item register, count and
// checksum state, output register. Depends on mfm_pkg and mfm_word_gen.
//
// Usage:
//   Slave stream: one data longword per transaction, with track and sector
//   number, 128 transactions per sector in order. Master stream: one
//   addressed 16-bit word of the 544-word sector image per transaction;
//   tlast marks the final word caused by one input longword.
//   Configuration: i_cfg_we writes sectors_per_track (reset 11); write it
//   only while the block is idle.
// Path: an accepted longword is registered in the item register, and its
//   words are then registered one by one in the output register.
// Throughput: the output register emits one word per cycle while tready
//   is high; a longword gives 4 words, the first of a sector 32 (preamble,
//   header, label, header checksum), the last 8 (data checksum); 544 per sector.
//   A new longword is taken in the cycle its predecessor's last word moves
//   to the output register, so the block streams without bubbles.
// Reset: clears the longword count, checksum, valid flags and sets
//   sectors_per_track back to 11.
// Stall: when the receiver drops tready the output word holds, the item
//   register holds its position, and slave tready drops once an item is held.
module mfm_sector_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,      // sectors_per_track
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // data_long[31:0], track_num[39:32],
                                          // sector_num[44:40], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // word_addr[9:0], word_value[25:10], zero pad
    output logic        o_m_axis_tlast    // last_word
);
    import mfm_pkg::*;

    logic [4:0]  r_spt;
    logic [6:0]  r_long_count;
    logic [31:0] r_csum;
    logic        r_item_valid;
    t_item       r_item;
    logic [4:0]  r_step;
    logic        r_out_valid;
    t_word       r_out;

    t_item       n_item;
    logic [31:0] n_csum;
    t_word       gen_word;
    logic        in_acc;
    logic        ld;

    logic [31:0] in_data;
    logic [7:0]  in_track;
    logic [4:0]  in_sector;
    logic [7:0]  gap;

    assign in_data   = i_s_axis_tdata[31:0];
    assign in_track  = i_s_axis_tdata[39:32];
    assign in_sector = i_s_axis_tdata[44:40];

    mfm_word_gen u_word_gen (
        .i_item (r_item),
        .i_step (r_step),
        .o_word (gen_word)
    );

    // move a word into the output register whenever it is free or draining
    assign ld              = r_item_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_item_valid || (ld && gen_word.last);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // header and checksum for the incoming longword
    assign gap    = {3'd0, r_spt} - {3'd0, in_sector};
    assign n_csum = ((r_long_count == 7'd0) ? 32'd0 : r_csum)
                  ^ ((in_data >> 1) & MASK_HALF) ^ (in_data & MASK_HALF);

    always_comb begin
        n_item.data  = in_data;
        n_item.hdr   = {FORMAT_BYTE, in_track, 3'd0, in_sector, gap};
        n_item.csum  = n_csum;
        n_item.idx   = r_long_count;
        n_item.first = (r_long_count == 7'd0);
        n_item.last  = (r_long_count == LONG_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt        <= SPT_RESET;
            r_long_count <= '0;
            r_csum       <= '0;
            r_item_valid <= 1'b0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spt <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_long_count <= r_long_count + 7'd1;
                r_csum       <= n_csum;
            end
            // advance through the words of the held item; drop it after its last word
            if (in_acc) begin
                r_item_valid <= 1'b1;
                r_step       <= '0;
            end else if (ld) begin
                if (gen_word.last) begin
                    r_item_valid <= 1'b0;
                    r_step       <= '0;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= n_item;
        end
        if (ld) begin
            r_out <= gen_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.value, r_out.addr};
    assign o_m_axis_tlast  = r_out.last;

    // the closing word of an item is the checksum tail or an even low data word
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
        (r_out.addr == 10'd31 || r_out.addr >= 10'd289))
        else $error("tlast on unexpected word address");

    // only the first longword of a sector runs past eight steps
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && !r_item.first) |-> (r_step < 5'd8))
        else $error("step counter out of range for a non-first longword");

    // a new item never overwrites one whose words are still pending
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_item_valid) |-> (ld && gen_word.last))
        else $error("item register overwritten before its last word");

    // after reset the sector starts at its first longword
    a_reset_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_long_count == 7'd0 && !r_item_valid))
        else $error("count or item not cleared by reset");

endmodule
